@@ rtl/hde_pkg.sv @@
`timescale 1ns / 1ps

package hde_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Multiplier operands carry one extra bit so that unsigned words and
  // signed differences share the same signed multiplier.
  localparam int OPND_WIDTH = WORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * OPND_WIDTH;
  localparam int DIV_CNT_W  = $clog2(WORD_WIDTH);

  typedef logic [WORD_WIDTH-1:0]        word_t;
  typedef logic signed [WORD_WIDTH-1:0] sword_t;
  typedef logic signed [OPND_WIDTH-1:0] opnd_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  localparam word_t GAIN_RESET = word_t'(6554);
  localparam word_t WORD_FULL  = {WORD_WIDTH{1'b1}};
  localparam word_t WORD_SMAX  = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_SMIN  = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic  sat;
    word_t value;
  } sclamp_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_status_t;

endpackage

@@ rtl/hde_node_if.sv @@
`timescale 1ns / 1ps

interface hde_node_if;
  import hde_pkg::*;

  logic   valid;
  logic   ready;
  sword_t temperature;
  word_t  conductivity;
  word_t  density;
  word_t  heat_capacity;
  logic   last_cell;

  modport source (
    output valid, temperature, conductivity, density, heat_capacity, last_cell,
    input  ready
  );

  modport sink (
    input  valid, temperature, conductivity, density, heat_capacity, last_cell,
    output ready
  );
endinterface

@@ rtl/hde_result_if.sv @@
`timescale 1ns / 1ps

interface hde_result_if;
  import hde_pkg::*;

  logic   valid;
  logic   ready;
  sword_t new_temperature;
  logic   saturated;
  logic   last_result;

  modport source (
    output valid, new_temperature, saturated, last_result,
    input  ready
  );

  modport sink (
    input  valid, new_temperature, saturated, last_result,
    output ready
  );
endinterface

@@ rtl/heat_diffusion_euler_stencil_core.sv @@
`timescale 1ns / 1ps

// One explicit Euler step of 1-D heat diffusion over a rod streamed one cell
// per item (signed Q16.16 temperature, unsigned Q16.16 material data). The
// core takes one cell at a time and is not ready while it works on it. A
// cell is only held, passes unchanged, releases an interior update or, as
// the rod's last cell, releases both; an item that waits on the result
// side holds the core. The 32-step restoring divider forms conductivity /
// (density * capacity); when the quotient would not fit in a word (a zero
// product included) the divider returns full scale at once and skips its
// loop. Every product goes through the shared 33x33 multiplier. An
// interior cell comes out when its right neighbor arrives; the rod's last
// cell can therefore release two items, interior one first. The first and
// last cells pass unchanged, and saturated marks any clamp.
// step_gain (dt/dx^2, unsigned Q16.16) may be written only while idle.
module heat_diffusion_euler_stencil_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  hde_pkg::word_t cfg_wr_data,
  hde_node_if.sink       node,
  hde_result_if.source   result
);
  import hde_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PMUL      = 4'd1;
  localparam logic [3:0] S_PCHK      = 4'd2;
  localparam logic [3:0] S_DIV       = 4'd3;
  localparam logic [3:0] S_DSEL      = 4'd4;
  localparam logic [3:0] S_MR        = 4'd5;
  localparam logic [3:0] S_ML        = 4'd6;
  localparam logic [3:0] S_FL        = 4'd7;
  localparam logic [3:0] S_GOP       = 4'd8;
  localparam logic [3:0] S_GMUL      = 4'd9;
  localparam logic [3:0] S_UPD       = 4'd10;
  localparam logic [3:0] S_SUM       = 4'd11;
  localparam logic [3:0] S_EMIT_MID  = 4'd12;
  localparam logic [3:0] S_EMIT_LAST = 4'd13;

  function automatic sclamp_t clamp_prod(input prod_t p);
    prod_t                            s;
    logic [PROD_WIDTH-WORD_WIDTH:0]   top;
    sclamp_t                          r;
    s   = p >>> FRAC_BITS;
    top = s[PROD_WIDTH-1:WORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      r.sat   = 1'b0;
      r.value = s[WORD_WIDTH-1:0];
    end else begin
      r.sat   = 1'b1;
      r.value = s[PROD_WIDTH-1] ? WORD_SMIN : WORD_SMAX;
    end
    return r;
  endfunction

  function automatic sclamp_t clamp_sum(input opnd_t s);
    sclamp_t r;
    if (s[WORD_WIDTH] == s[WORD_WIDTH-1]) begin
      r.sat   = 1'b0;
      r.value = s[WORD_WIDTH-1:0];
    end else begin
      r.sat   = 1'b1;
      r.value = s[WORD_WIDTH] ? WORD_SMIN : WORD_SMAX;
    end
    return r;
  endfunction

  logic [3:0] state;
  logic [1:0] cells_seen;
  word_t      step_gain;

  // Cell under work.
  word_t      t_q;
  word_t      k_q;
  word_t      d_q;
  logic       last_q;
  logic       dsat;

  // Window: left and center neighbors of the incoming cell.
  word_t      t_left;
  word_t      t_ctr;
  word_t      d_left;
  word_t      d_ctr;

  opnd_t      op_a;
  opnd_t      op_b;
  prod_t      prod;
  word_t      fr;
  word_t      fl;
  word_t      upd;
  logic       sat_acc;

  logic       out_valid;
  word_t      out_temp;
  logic       out_sat;
  logic       out_last;

  logic                  div_start;
  word_t                 div_divisor;
  word_t                 div_quot;
  div_status_t           div_stat;
  logic                  prod_over;
  logic [WORD_WIDTH:0]   sum_r;
  logic [WORD_WIDTH:0]   sum_l;
  word_t                 mean_r;
  word_t                 mean_l;
  sclamp_t               prod_cl;
  sclamp_t               nt_cl;
  logic                  commit;
  logic                  interior;

  assign prod_over   = |prod[2*WORD_WIDTH-1:WORD_WIDTH+FRAC_BITS];
  assign div_divisor = prod_over ? WORD_FULL : prod[WORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
  assign div_start   = (state == S_PCHK);

  assign sum_r   = {1'b0, d_ctr} + {1'b0, d_q};
  assign sum_l   = {1'b0, d_left} + {1'b0, d_ctr};
  assign mean_r  = sum_r[WORD_WIDTH:1];
  assign mean_l  = sum_l[WORD_WIDTH:1];
  assign prod_cl = clamp_prod(prod);
  assign nt_cl   = clamp_sum({t_ctr[WORD_WIDTH-1], t_ctr} + {upd[WORD_WIDTH-1], upd});

  // cells_seen of three behaves as two.
  assign interior = cells_seen[1];
  assign commit   = ((state == S_DSEL) && !interior) || (state == S_SUM);

  hde_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (k_q),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_stat)
  );

  // The shared multiplier runs every cycle; the sequencer decides when the
  // product register holds something of use.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cells_seen <= 2'd0;
      step_gain  <= GAIN_RESET;
      out_valid  <= 1'b0;
      t_left     <= '0;
      t_ctr      <= '0;
      d_left     <= '0;
      d_ctr      <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_gain <= cfg_wr_data;
      end

      if (commit) begin
        if (cells_seen == 2'd0) begin
          if (!last_q) begin
            t_ctr      <= t_q;
            d_ctr      <= d_q;
            cells_seen <= 2'd1;
          end
        end else if (last_q) begin
          t_left     <= '0;
          t_ctr      <= '0;
          d_left     <= '0;
          d_ctr      <= '0;
          cells_seen <= 2'd0;
        end else begin
          t_left     <= t_ctr;
          d_left     <= d_ctr;
          t_ctr      <= t_q;
          d_ctr      <= d_q;
          cells_seen <= 2'd2;
        end
      end

      case (state)
        S_IDLE: begin
          if (node.valid) begin
            t_q    <= node.temperature;
            k_q    <= node.conductivity;
            last_q <= node.last_cell;
            op_a   <= {1'b0, node.density};
            op_b   <= {1'b0, node.heat_capacity};
            state  <= S_PMUL;
          end
        end
        S_PMUL: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          dsat  <= prod_over;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            d_q   <= div_quot;
            dsat  <= dsat | div_stat.ovf;
            state <= S_DSEL;
          end
        end
        S_DSEL: begin
          if (interior) begin
            sat_acc <= dsat || (d_left == WORD_FULL) || (d_ctr == WORD_FULL)
                       || (d_q == WORD_FULL);
            op_a    <= {1'b0, mean_r};
            op_b    <= {t_q[WORD_WIDTH-1], t_q} - {t_ctr[WORD_WIDTH-1], t_ctr};
            state   <= S_MR;
          end else if ((cells_seen == 2'd0) || last_q) begin
            out_temp  <= t_q;
            out_sat   <= dsat;
            out_last  <= last_q;
            out_valid <= 1'b1;
            state     <= S_EMIT_LAST;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MR: begin
          op_a  <= {1'b0, mean_l};
          op_b  <= {t_ctr[WORD_WIDTH-1], t_ctr} - {t_left[WORD_WIDTH-1], t_left};
          state <= S_ML;
        end
        S_ML: begin
          fr      <= prod_cl.value;
          sat_acc <= sat_acc | prod_cl.sat;
          state   <= S_FL;
        end
        S_FL: begin
          fl      <= prod_cl.value;
          sat_acc <= sat_acc | prod_cl.sat;
          state   <= S_GOP;
        end
        S_GOP: begin
          op_a  <= {1'b0, step_gain};
          op_b  <= {fr[WORD_WIDTH-1], fr} - {fl[WORD_WIDTH-1], fl};
          state <= S_GMUL;
        end
        S_GMUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          upd     <= prod_cl.value;
          sat_acc <= sat_acc | prod_cl.sat;
          state   <= S_SUM;
        end
        S_SUM: begin
          out_temp  <= nt_cl.value;
          out_sat   <= sat_acc | nt_cl.sat;
          out_last  <= 1'b0;
          out_valid <= 1'b1;
          state     <= S_EMIT_MID;
        end
        S_EMIT_MID: begin
          if (result.ready) begin
            if (last_q) begin
              // The rod's last cell follows its left neighbor's update.
              out_temp <= t_q;
              out_sat  <= dsat;
              out_last <= 1'b1;
              state    <= S_EMIT_LAST;
            end else begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        S_EMIT_LAST: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  assign node.ready             = (state == S_IDLE) && !rst;
  assign result.valid           = out_valid;
  assign result.new_temperature = out_temp;
  assign result.saturated       = out_sat;
  assign result.last_result     = out_last;

endmodule

@@ rtl/hde_div.sv @@
`timescale 1ns / 1ps

// Restoring divider for floor(dividend * 2^FRAC_BITS / divisor), one quotient
// bit per cycle. A quotient that would not fit in a word is detected before
// the loop starts (this also covers a zero divisor) and returns full scale.
module hde_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hde_pkg::word_t      dividend,
  input  hde_pkg::word_t      divisor,
  output hde_pkg::word_t      quotient,
  output hde_pkg::div_status_t status
);
  import hde_pkg::*;

  localparam int HI_BITS = WORD_WIDTH - FRAC_BITS;
  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(WORD_WIDTH - 1);

  logic                  busy;
  logic                  done;
  logic                  ovf;
  logic [DIV_CNT_W-1:0]  cnt;
  word_t                 rem;
  word_t                 sh;
  word_t                 dvs;
  word_t                 hi_part;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH:0]   diff;
  logic                  ge;

  assign hi_part = {{HI_BITS{1'b0}}, dividend[WORD_WIDTH-1:HI_BITS]};
  assign trial   = {rem, sh[WORD_WIDTH-1]};
  assign diff    = trial - {1'b0, dvs};
  assign ge      = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (hi_part >= divisor) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf <= (hi_part >= divisor);
      rem <= hi_part;
      sh  <= {dividend[HI_BITS-1:0], {FRAC_BITS{1'b0}}};
      dvs <= divisor;
      cnt <= CNT_LAST;
    end else if (busy) begin
      rem <= ge ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
      sh  <= {sh[WORD_WIDTH-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient    = ovf ? WORD_FULL : sh;
  assign status.done = done;
  assign status.ovf  = ovf;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import hde_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  typedef struct {
    sword_t temperature;
    word_t  conductivity;
    word_t  density;
    word_t  heat_capacity;
    logic   last_cell;
  } cell_t;

  typedef struct {
    sword_t temperature;
    logic   sat;
    logic   is_last;
  } cell_update_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_wr_en;
  word_t cfg_wr_data;

  hde_node_if   node_ch ();
  hde_result_if res_ch ();

  heat_diffusion_euler_stencil_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .node        (node_ch),
    .result      (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block's state, updated at each accepted item.
  word_t        rod_gain;
  sword_t       rod_temp [2];
  word_t        rod_diff [2];
  int           rod_cells;
  cell_update_t pending_updates [$];

  int       failures;
  int       cycle_count;
  int       hold_cycles;
  rx_mode_e rx_mode;
  int       rx_period;
  int       rx_stall;
  int       rx_phase;

  // conductivity / (density * capacity) in Q16.16, clamped to full scale.
  function automatic word_t cell_diffusivity(cell_t c, output bit sat);
    logic [63:0] rho_cp;
    logic [95:0] quot;
    sat = 1'b0;
    rho_cp = (64'(c.density) * 64'(c.heat_capacity)) >> FRAC_BITS;
    if (rho_cp > 64'(WORD_FULL)) begin
      sat = 1'b1;
      rho_cp = 64'(WORD_FULL);
    end
    if (rho_cp == 64'd0) begin
      sat = 1'b1;
      return WORD_FULL;
    end
    quot = (96'(c.conductivity) << FRAC_BITS) / 96'(rho_cp);
    if (quot > 96'(WORD_FULL)) begin
      sat = 1'b1;
      return WORD_FULL;
    end
    return quot[WORD_WIDTH-1:0];
  endfunction

  // Unsigned Q16.16 times signed value, floored, clamped to the signed range.
  function automatic longint q_mul_floor(word_t a, longint b, inout bit sat);
    logic         neg;
    logic [63:0]  mag;
    logic [63:0]  limit;
    logic [127:0] full;
    logic [127:0] q;
    neg = (b < 0);
    mag = neg ? -b : b;
    limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    full = 128'(a) * 128'(mag);
    q = full >> FRAC_BITS;
    if (q > 128'(limit)) begin
      sat = 1'b1;
      q = 128'(limit);
    end else if (neg && full[FRAC_BITS-1:0] != '0) begin
      q = q + 1;
      if (q > 128'(limit)) begin
        sat = 1'b1;
        q = 128'(limit);
      end
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic void predict_cell_update(cell_t c);
    bit           dsat;
    bit           sat;
    word_t        d;
    logic [32:0]  sum_r;
    logic [32:0]  sum_l;
    longint       tl;
    longint       tc;
    longint       tn;
    longint       fr;
    longint       fl;
    longint       nt;
    cell_update_t upd;
    d = cell_diffusivity(c, dsat);
    if (rod_cells == 0) begin
      upd.temperature = c.temperature;
      upd.sat = dsat;
      upd.is_last = c.last_cell;
      pending_updates.push_back(upd);
      if (!c.last_cell) begin
        rod_temp[1] = c.temperature;
        rod_diff[1] = d;
        rod_cells = 1;
      end
      return;
    end
    if (rod_cells >= 2) begin
      tl = rod_temp[0];
      tc = rod_temp[1];
      tn = c.temperature;
      sat = dsat || rod_diff[0] == WORD_FULL || rod_diff[1] == WORD_FULL || d == WORD_FULL;
      sum_r = 33'(rod_diff[1]) + 33'(d);
      sum_l = 33'(rod_diff[0]) + 33'(rod_diff[1]);
      fr = q_mul_floor(sum_r[32:1], tn - tc, sat);
      fl = q_mul_floor(sum_l[32:1], tc - tl, sat);
      nt = tc + q_mul_floor(rod_gain, fr - fl, sat);
      if (nt > 64'sh7FFF_FFFF) begin
        sat = 1'b1;
        nt = 64'sh7FFF_FFFF;
      end else if (nt < -64'sh8000_0000) begin
        sat = 1'b1;
        nt = -64'sh8000_0000;
      end
      upd.temperature = sword_t'(nt);
      upd.sat = sat;
      upd.is_last = 1'b0;
      pending_updates.push_back(upd);
    end
    if (c.last_cell) begin
      upd.temperature = c.temperature;
      upd.sat = dsat;
      upd.is_last = 1'b1;
      pending_updates.push_back(upd);
      rod_temp[0] = '0;
      rod_temp[1] = '0;
      rod_diff[0] = '0;
      rod_diff[1] = '0;
      rod_cells = 0;
      return;
    end
    rod_temp[0] = rod_temp[1];
    rod_diff[0] = rod_diff[1];
    rod_temp[1] = c.temperature;
    rod_diff[1] = d;
    rod_cells = 2;
  endfunction

  function automatic cell_t mk_cell(sword_t t, word_t k, word_t rho, word_t cp, logic last);
    cell_t c;
    c.temperature = t;
    c.conductivity = k;
    c.density = rho;
    c.heat_capacity = cp;
    c.last_cell = last;
    return c;
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return word_t'(1);
      2: return word_t'(32'h0000_FFFF);
      3: return word_t'(32'h0001_0000);
      4: return WORD_SMAX;
      5: return WORD_SMIN;
      default: return WORD_FULL;
    endcase
  endfunction

  // Mostly plausible material data so that most updates stay unclamped.
  function automatic cell_t random_cell(logic last);
    cell_t c;
    case ($urandom_range(0, 9))
      0, 1: c = mk_cell($urandom, $urandom, $urandom, $urandom, last);
      2: c = mk_cell(corner_word(), corner_word(), corner_word(), corner_word(), last);
      default: begin
        c = mk_cell(sword_t'($urandom_range(0, 13107200)) - sword_t'(6553600),
                    $urandom_range(32'h0000_4000, 32'h0004_0000),
                    $urandom_range(32'h0000_8000, 32'h0002_0000),
                    $urandom_range(32'h0000_8000, 32'h0002_0000), last);
      end
    endcase
    return c;
  endfunction

  task automatic note_failure(input string what);
    failures = failures + 1;
    if (failures <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // Leaves valid high, so a following item is offered without a gap.
  task automatic send_cell(input cell_t c);
    node_ch.valid <= 1'b1;
    node_ch.temperature <= c.temperature;
    node_ch.conductivity <= c.conductivity;
    node_ch.density <= c.density;
    node_ch.heat_capacity <= c.heat_capacity;
    node_ch.last_cell <= c.last_cell;
    do @(posedge clk); while (node_ch.ready !== 1'b1);
    predict_cell_update(c);
  endtask

  task automatic pause_sender(input int cycles);
    node_ch.valid <= 1'b0;
    node_ch.temperature <= $urandom;
    node_ch.conductivity <= $urandom;
    node_ch.density <= $urandom;
    node_ch.heat_capacity <= $urandom;
    node_ch.last_cell <= $urandom_range(0, 1);
    repeat (cycles) @(posedge clk);
  endtask

  // A held cell produces no item, so the core may still be busy after the
  // last expected item; the settle time covers that.
  task automatic wait_drained();
    node_ch.valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input word_t value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rod_gain = value;
  endtask

  task automatic run_rods(input int n_items, input int max_gap);
    int sent;
    int rod_len;
    int burst_left;
    sent = 0;
    burst_left = $urandom_range(1, 16);
    while (sent < n_items) begin
      rod_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      for (int i = 0; i < rod_len; i++) begin
        send_cell(random_cell(i == rod_len - 1));
        sent = sent + 1;
        burst_left = burst_left - 1;
        if (max_gap > 0 && burst_left == 0) begin
          pause_sender($urandom_range(1, max_gap));
          burst_left = $urandom_range(1, 16);
        end
      end
    end
  endtask

  task automatic set_receiver(input rx_mode_e mode);
    rx_mode = mode;
    rx_period = $urandom_range(3, 8);
    rx_stall = $urandom_range(1, rx_period - 1);
  endtask

  task automatic test_boundary_rods();
    // Single-cell rod with a zero density: clamped diffusivity, passed through.
    send_cell(mk_cell(WORD_SMIN, WORD_FULL, '0, WORD_FULL, 1'b1));
    // Two-cell rod: an oversized density product, then an oversized quotient.
    send_cell(mk_cell(WORD_SMAX, '0, WORD_FULL, WORD_FULL, 1'b0));
    send_cell(mk_cell('0, WORD_FULL, 32'h100, 32'h100, 1'b1));
    // Unit diffusivity with full-range temperature jumps clamps the fluxes.
    send_cell(mk_cell('0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(32'h64_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(-32'sh32_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(WORD_SMAX, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(WORD_SMIN, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b1));
  endtask

  task automatic test_gain_extremes();
    wait_drained();
    write_gain('0);
    send_cell(mk_cell(WORD_SMIN, 32'h2_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(WORD_SMAX, 32'h2_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(-32'sh1, 32'h2_0000, 32'h1_0000, 32'h1_0000, 1'b1));
    wait_drained();
    write_gain(WORD_FULL);
    send_cell(mk_cell(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(32'h2_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell('0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(32'h1, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b1));
    wait_drained();
    // A zero-density cell in the middle puts a full-scale diffusivity in the window.
    write_gain(32'h1000);
    send_cell(mk_cell(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(32'h1_0000, 32'h1_0000, '0, 32'h1_0000, 1'b0));
    send_cell(mk_cell(32'h1_8000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
    send_cell(mk_cell(32'h0_8000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b1));
  endtask

  // The result side is blocked long enough for the core to stop taking cells.
  task automatic test_output_backpressure();
    wait_drained();
    write_gain(GAIN_RESET);
    set_receiver(RX_ALWAYS);
    hold_cycles = 600;
    run_rods(24, 0);
    wait_drained();
  endtask

  task automatic test_random_rods();
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0: write_gain($urandom);
        1: write_gain(corner_word());
        default: write_gain($urandom_range(0, 32'h8000));
      endcase
      if (ph == 1) begin
        set_receiver(RX_ALWAYS);
        run_rods(200, 0);
      end else begin
        set_receiver(rx_mode_e'(ph % 3));
        run_rods(200, $urandom_range(1, 8));
      end
    end
  endtask

  always @(posedge clk) begin
    cell_update_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_updates.size() == 0) begin
        note_failure($sformatf("unexpected item temperature=%h saturated=%b last=%b",
                               res_ch.new_temperature, res_ch.saturated, res_ch.last_result));
      end else begin
        want = pending_updates.pop_front();
        if (res_ch.new_temperature !== want.temperature || res_ch.saturated !== want.sat ||
            res_ch.last_result !== want.is_last) begin
          note_failure($sformatf("expected %h/%b/%b got %h/%b/%b",
                                 want.temperature, want.sat, want.is_last,
                                 res_ch.new_temperature, res_ch.saturated,
                                 res_ch.last_result));
        end
      end
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    rx_phase = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: res_ch.ready <= 1'b1;
          RX_RANDOM: res_ch.ready <= ($urandom_range(0, 2) != 0);
          default: begin
            rx_phase = (rx_phase + 1) % rx_period;
            res_ch.ready <= (rx_phase >= rx_stall);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    node_ch.valid <= 1'b0;
    node_ch.temperature <= '0;
    node_ch.conductivity <= '0;
    node_ch.density <= '0;
    node_ch.heat_capacity <= '0;
    node_ch.last_cell <= 1'b0;
    cycle_count = 0;
    failures = 0;
    hold_cycles = 0;
    rod_gain = GAIN_RESET;
    rod_temp[0] = '0;
    rod_temp[1] = '0;
    rod_diff[0] = '0;
    rod_diff[1] = '0;
    rod_cells = 0;
    set_receiver(RX_RANDOM);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_boundary_rods();
    test_gain_extremes();
    test_output_backpressure();
    test_random_rods();

    wait_drained();
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hde_pkg.sv
rtl/hde_node_if.sv
rtl/hde_result_if.sv
rtl/hde_div.sv
rtl/heat_diffusion_euler_stencil_core.sv
tb/tb_top.sv
